@@ rtl/core/lc3ie_pkg.sv @@
`timescale 1ns / 1ps

package lc3ie_pkg;

    // Machine constants.
    localparam int unsigned ADDR_BITS_DEFAULT = 16;
    localparam logic [15:0] START_PC_RESET    = 16'h3000;

    // Condition code encodings.
    localparam logic [2:0] CC_P = 3'd1;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_N = 3'd4;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 80;

    // Register that JSR/JSRR link into.
    localparam logic [2:0] LINK_REG = 3'd7;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } opcode_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] instr_word;
        logic [15:0] load_addr;
        logic [15:0] load_data;
    } item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [2:0]  cond_flags;
        logic        reg_written;
        logic [2:0]  dest_reg;
        logic [15:0] dest_value;
        logic        mem_written;
        logic [15:0] store_addr;
        logic [15:0] store_data;
        logic        unsupported;
    } res_t;

    // Word memory access request; addresses are full width and cut down in the memory.
    typedef struct packed {
        logic        rd_en;
        logic [15:0] rd_addr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [15:0] wr_data;
    } mem_req_t;

    // Register file access request.
    typedef struct packed {
        logic        rd_en;
        logic [2:0]  rd_addr_a;
        logic [2:0]  rd_addr_b;
        logic        wr_en;
        logic [2:0]  wr_addr;
        logic [15:0] wr_data;
    } rf_req_t;

endpackage

@@ rtl/core/lc3ie_regfile.sv @@
`timescale 1ns / 1ps

module lc3ie_regfile
    import lc3ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rf_req_t     rf_req,
    output logic [15:0] rd_a,
    output logic [15:0] rd_b
);

    // Entries without a valid bit have not been written since reset and read as zero.
    logic [15:0] rf_mem [8];
    logic [7:0]  valid_reg;
    logic [15:0] rd_a_reg;
    logic [15:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (rf_req.wr_en) begin
            valid_reg[rf_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_req.wr_en) begin
            rf_mem[rf_req.wr_addr] <= rf_req.wr_data;
        end
        if (rf_req.rd_en) begin
            rd_a_reg <= valid_reg[rf_req.rd_addr_a] ? rf_mem[rf_req.rd_addr_a] : 16'd0;
            rd_b_reg <= valid_reg[rf_req.rd_addr_b] ? rf_mem[rf_req.rd_addr_b] : 16'd0;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

@@ rtl/core/lc3ie_wmem.sv @@
`timescale 1ns / 1ps

module lc3ie_wmem
    import lc3ie_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic        aclk,
    input  mem_req_t    mem_req,
    output logic [15:0] rd_data
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [15:0] mem_array [DEPTH];
    logic [15:0] rd_data_reg;

    // The read data register only moves on a read, so a stalled consumer sees stable data.
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem_array[mem_req.wr_addr[ADDR_BITS-1:0]] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem_array[mem_req.rd_addr[ADDR_BITS-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lc3ie_ctrl.sv @@
`timescale 1ns / 1ps

module lc3ie_ctrl
    import lc3ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] start_pc,
    output logic        cfg_open,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_take,
    input  logic        out_free,
    output logic        res_valid,
    output res_t        res,
    output mem_req_t    mem_req,
    input  logic [15:0] mem_rdata,
    output rf_req_t     rf_req,
    input  logic [15:0] rf_a,
    input  logic [15:0] rf_b
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXE,
        S_MEM
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic [15:0] instr_reg, instr_next;

    // Decode of the incoming item, used to launch the first reads.
    opcode_t     op_in;
    logic [15:0] pc_inc;
    logic [15:0] addr9_in;

    // Decode of the instruction in flight.
    opcode_t     op;
    logic [2:0]  r0;
    logic [15:0] off9, off6, off11, imm5;
    logic [15:0] src2, addr9, addr6;

    logic        ex_rw, ex_mw, ex_uns, ex_need_mem;
    logic [2:0]  ex_dr;
    logic [15:0] ex_dv, ex_sa, ex_sd, ex_pc, ex_mem_addr;

    logic        fin_go;
    logic [15:0] fin_dv;
    logic        fin_cc_upd;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v == 16'd0) begin
            return CC_Z;
        end else if (v[15]) begin
            return CC_N;
        end
        return CC_P;
    endfunction

    assign pc_inc   = pc_reg + 16'd1;
    assign op_in    = opcode_t'(item.instr_word[15:12]);
    assign addr9_in = pc_inc + {{7{item.instr_word[8]}}, item.instr_word[8:0]};

    assign op    = opcode_t'(instr_reg[15:12]);
    assign r0    = instr_reg[11:9];
    assign off9  = {{7{instr_reg[8]}}, instr_reg[8:0]};
    assign off6  = {{10{instr_reg[5]}}, instr_reg[5:0]};
    assign off11 = {{5{instr_reg[10]}}, instr_reg[10:0]};
    assign imm5  = {{11{instr_reg[4]}}, instr_reg[4:0]};
    assign src2  = instr_reg[5] ? imm5 : rf_b;
    assign addr9 = pc_inc + off9;
    assign addr6 = rf_a + off6;

    // Execute step: operands come from the register file and the first memory read.
    always_comb begin
        ex_rw       = 1'b0;
        ex_dr       = 3'd0;
        ex_dv       = 16'd0;
        ex_mw       = 1'b0;
        ex_sa       = 16'd0;
        ex_sd       = 16'd0;
        ex_uns      = 1'b0;
        ex_pc       = pc_inc;
        ex_need_mem = 1'b0;
        ex_mem_addr = addr6;
        case (op)
            OP_BR: begin
                if ((r0 & cc_reg) != 3'd0) begin
                    ex_pc = addr9;
                end
            end
            OP_ADD: begin
                ex_rw = 1'b1;
                ex_dr = r0;
                ex_dv = rf_a + src2;
            end
            OP_AND: begin
                ex_rw = 1'b1;
                ex_dr = r0;
                ex_dv = rf_a & src2;
            end
            OP_NOT: begin
                ex_rw = 1'b1;
                ex_dr = r0;
                ex_dv = ~rf_a;
            end
            OP_LD: begin
                ex_rw = 1'b1;
                ex_dr = r0;
                ex_dv = mem_rdata;
            end
            OP_LDI: begin
                ex_rw       = 1'b1;
                ex_dr       = r0;
                ex_need_mem = 1'b1;
                ex_mem_addr = mem_rdata;
            end
            OP_LDR: begin
                ex_rw       = 1'b1;
                ex_dr       = r0;
                ex_need_mem = 1'b1;
                ex_mem_addr = addr6;
            end
            OP_LEA: begin
                ex_rw = 1'b1;
                ex_dr = r0;
                ex_dv = addr9;
            end
            OP_ST: begin
                ex_mw = 1'b1;
                ex_sa = addr9;
                ex_sd = rf_b;
            end
            OP_STI: begin
                ex_mw = 1'b1;
                ex_sa = mem_rdata;
                ex_sd = rf_b;
            end
            OP_STR: begin
                ex_mw = 1'b1;
                ex_sa = addr6;
                ex_sd = rf_b;
            end
            OP_JMP: begin
                ex_pc = rf_a;
            end
            OP_JSR: begin
                // The JSRR target was read before R7 takes the link value.
                ex_rw = 1'b1;
                ex_dr = LINK_REG;
                ex_dv = pc_inc;
                ex_pc = instr_reg[11] ? (pc_inc + off11) : rf_a;
            end
            OP_RTI, OP_RES, OP_TRAP: begin
                ex_uns = 1'b1;
            end
            default: begin
                ex_uns = 1'b1;
            end
        endcase
    end

    assign fin_go     = out_free && (((state_reg == S_EXE) && !ex_need_mem)
                                     || (state_reg == S_MEM));
    assign fin_dv     = (state_reg == S_MEM) ? mem_rdata : ex_dv;
    assign fin_cc_upd = ex_rw && (op != OP_JSR);

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cc_next    = cc_reg;
        instr_next = instr_reg;
        item_take  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        mem_req    = '0;
        rf_req     = '0;
        case (state_reg)
            S_INIT: begin
                pc_next    = start_pc;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (item_valid) begin
                    if (item.req_type) begin
                        if (out_free) begin
                            item_take       = 1'b1;
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = item.load_addr;
                            mem_req.wr_data = item.load_data;
                            res_valid       = 1'b1;
                            res.next_pc     = pc_reg;
                            res.cond_flags  = cc_reg;
                        end
                    end else begin
                        item_take        = 1'b1;
                        instr_next       = item.instr_word;
                        rf_req.rd_en     = 1'b1;
                        rf_req.rd_addr_a = item.instr_word[8:6];
                        if (op_in == OP_ST || op_in == OP_STI || op_in == OP_STR) begin
                            rf_req.rd_addr_b = item.instr_word[11:9];
                        end else begin
                            rf_req.rd_addr_b = item.instr_word[2:0];
                        end
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = addr9_in;
                        state_next      = S_EXE;
                    end
                end
            end
            S_EXE: begin
                if (ex_need_mem) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ex_mem_addr;
                    state_next      = S_MEM;
                end
            end
            S_MEM: begin
                state_next = S_MEM;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Retire the instruction: commit every side effect and emit the result together.
        if (fin_go) begin
            res_valid       = 1'b1;
            res.next_pc     = ex_pc;
            res.cond_flags  = fin_cc_upd ? cc_of(fin_dv) : cc_reg;
            res.reg_written = ex_rw;
            res.dest_reg    = ex_dr;
            res.dest_value  = ex_rw ? fin_dv : 16'd0;
            res.mem_written = ex_mw;
            res.store_addr  = ex_sa;
            res.store_data  = ex_sd;
            res.unsupported = ex_uns;
            rf_req.wr_en    = ex_rw;
            rf_req.wr_addr  = ex_dr;
            rf_req.wr_data  = fin_dv;
            mem_req.wr_en   = ex_mw;
            mem_req.wr_addr = ex_sa;
            mem_req.wr_data = ex_sd;
            pc_next         = ex_pc;
            if (fin_cc_upd) begin
                cc_next = cc_of(fin_dv);
            end
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            pc_reg    <= START_PC_RESET;
            cc_reg    <= CC_Z;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cc_reg    <= cc_next;
        end
        instr_reg <= instr_next;
    end

    assign cfg_open = (state_reg != S_INIT);

    ap_mem_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("word memory read and written in the same cycle");

    ap_res_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result produced while the output register is full");

    ap_rf_wr_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (rf_req.wr_en || mem_req.wr_en) |-> res_valid)
        else $error("state written without a retiring result");

    ap_instr_to_exe: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && !item.req_type) |=> (state_reg == S_EXE))
        else $error("instruction taken but execute step did not follow");

endmodule

@@ rtl/core/lc3_instruction_executor_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata: instr_word, load_addr, load_data;
//                                          s_tuser: req_type
// m_        out        m_tvalid/m_tready   m_tdata: the nine result fields
// cfg_      in         cfg_valid/cfg_ready cfg_data: start_pc
//
// A load request retires when the sequencer takes it. ADD, AND, NOT, BR, JMP, JSR, LEA,
// LD, ST, STI, STR and unsupported opcodes retire from the execute step; LDI and LDR
// add a memory step: the word memory has one synchronous read port, and they read twice.
// One input transaction can wait in the input buffer while another executes, and a
// finished result waits in the output register while the next instruction runs; the
// sequencer only stalls at retirement when that register is still occupied.
// Reset is synchronous and active low. In the cycle after reset the sequencer loads the
// PC from start_pc and takes nothing, and the configuration channel is not yet ready;
// the input buffer can already accept one transaction. Memory is not cleared by reset.

module lc3_instruction_executor_top
    import lc3ie_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] instr_word, [31:16] load_addr, [47:32] load_data
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] next_pc, [18:16] cond_flags, [19] reg_written, [22:20] dest_reg,
    // [38:23] dest_value, [39] mem_written, [55:40] store_addr, [71:56] store_data,
    // [72] unsupported, [79:73] zero
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    logic        cfg_open;
    logic [15:0] start_pc_reg;

    item_t       buf_item_reg;
    logic        buf_valid_reg;
    logic        item_take;

    res_t        res, res_reg;
    logic        res_valid;
    logic        m_tvalid_reg;
    logic        out_free;

    mem_req_t    mem_req;
    logic [15:0] mem_rdata;
    rf_req_t     rf_req;
    logic [15:0] rf_a, rf_b;

    // The start PC register is sampled by the sequencer in the cycle after reset.
    assign cfg_ready = cfg_open;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= START_PC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            start_pc_reg <= cfg_data;
        end
    end

    // Input buffer: one entry, refilled in the same cycle that the sequencer drains it.
    assign s_tready = !buf_valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            buf_valid_reg <= 1'b1;
        end else if (item_take) begin
            buf_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            buf_item_reg.req_type   <= s_tuser;
            buf_item_reg.instr_word <= s_tdata[15:0];
            buf_item_reg.load_addr  <= s_tdata[31:16];
            buf_item_reg.load_data  <= s_tdata[47:32];
        end
    end

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, res_reg.unsupported, res_reg.store_data, res_reg.store_addr,
                       res_reg.mem_written, res_reg.dest_value, res_reg.dest_reg,
                       res_reg.reg_written, res_reg.cond_flags, res_reg.next_pc};

    lc3ie_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_pc   (start_pc_reg),
        .cfg_open   (cfg_open),
        .item_valid (buf_valid_reg),
        .item       (buf_item_reg),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .rf_req     (rf_req),
        .rf_a       (rf_a),
        .rf_b       (rf_b)
    );

    lc3ie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rf_req  (rf_req),
        .rd_a    (rf_a),
        .rd_b    (rf_b)
    );

    lc3ie_wmem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_wmem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (mem_rdata)
    );

endmodule
